FILE: sv/mgpu_pkg.sv
// Shared types, constants and helpers for the momentum/gain point update.
package mgpu_pkg;

   localparam int DIV_BITS = 48;
   localparam int LANE_LAT = DIV_BITS + 6;

   localparam logic [1:0] REG_LEARNING_RATE       = 2'd0;
   localparam logic [1:0] REG_FORCE_NORMALIZATION = 2'd1;
   localparam logic [1:0] REG_MOMENTUM_FACTOR     = 2'd2;
   localparam logic [1:0] REG_ATTRACTION_SCALE    = 2'd3;

   localparam logic [30:0] RST_LEARNING_RATE       = 31'd13107200;
   localparam logic [30:0] RST_FORCE_NORMALIZATION = 31'd65536;
   localparam logic [16:0] RST_MOMENTUM_FACTOR     = 17'd32768;
   localparam logic [30:0] RST_ATTRACTION_SCALE    = 31'd65536;

   localparam logic [15:0] GAIN_ADD   = 16'd13107;
   localparam logic [15:0] GAIN_MUL   = 16'd52429;
   localparam logic [30:0] GAIN_FLOOR = 31'd655;
   localparam logic [30:0] MAX31      = 31'h7fffffff;

   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] attract_x;
      logic signed [31:0] attract_y;
      logic signed [31:0] repel_x;
      logic signed [31:0] repel_y;
      logic signed [31:0] prev_step_x;
      logic signed [31:0] prev_step_y;
      logic [30:0]        gain_in_x;
      logic [30:0]        gain_in_y;
      logic               last_point_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_point_x;
      logic signed [31:0] new_point_y;
      logic signed [31:0] new_step_x;
      logic signed [31:0] new_step_y;
      logic [30:0]        gain_out_x;
      logic [30:0]        gain_out_y;
      logic               last_point_out;
   } rsp_type;

   typedef struct packed {
      logic [30:0] learning_rate;
      logic [30:0] force_normalization;
      logic [16:0] momentum_factor;
      logic [30:0] attraction_scale;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               tag;
      logic signed [31:0] point;
      logic signed [31:0] attract;
      logic signed [31:0] repel;
      logic signed [31:0] prev;
      logic [30:0]        gain;
   } lane_in_type;

   typedef struct packed {
      logic               valid;
      logic               tag;
      logic signed [31:0] new_point;
      logic signed [31:0] new_step;
      logic [30:0]        gain_out;
   } lane_out_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] qd;
      logic [30:0]         rem;
      logic                neg;
      logic signed [46:0]  attr;
      logic signed [31:0]  point;
      logic signed [31:0]  prev;
      logic [30:0]         gain;
      logic                tag;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
      logic signed [31:0] y;
      if (x > SAT_HI) begin
         y = 32'sh7fffffff;
      end else if (x < SAT_LO) begin
         y = 32'sh80000000;
      end else begin
         y = x[31:0];
      end
      return y;
   endfunction

endpackage

FILE: sv/momentum_gain_point_update.sv
// Top level: configuration registers, x and y lanes, result merge.
// One point word is taken in every clock cycle (start high, busy is never raised) and
// its result word appears on rsp_valid/rsp_data, one word per cycle in input order.
// The result path runs through the input stage, the 48-stage restoring divider that
// forms repel/force_normalization, five arithmetic stages (gradient, gain pick,
// eta*gain and momentum, eta*gain*gradient, update) and the output register.
// Results cannot be held off; the receiver must take each word in the cycle it shows.
// Write csr_ registers only while no word is in flight.
module momentum_gain_point_update (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mgpu_pkg::req_type req_data,
   output logic              rsp_valid,
   output mgpu_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   logic [30:0] learning_rate_ff;
   logic [30:0] force_normalization_ff;
   logic [16:0] momentum_factor_ff;
   logic [30:0] attraction_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learning_rate_ff       <= mgpu_pkg::RST_LEARNING_RATE;
         force_normalization_ff <= mgpu_pkg::RST_FORCE_NORMALIZATION;
         momentum_factor_ff     <= mgpu_pkg::RST_MOMENTUM_FACTOR;
         attraction_scale_ff    <= mgpu_pkg::RST_ATTRACTION_SCALE;
      end else if (csr_write) begin
         unique case (csr_index)
            mgpu_pkg::REG_LEARNING_RATE: begin
               learning_rate_ff <= csr_wdata;
            end
            mgpu_pkg::REG_FORCE_NORMALIZATION: begin
               force_normalization_ff <= csr_wdata;
            end
            mgpu_pkg::REG_MOMENTUM_FACTOR: begin
               momentum_factor_ff <= csr_wdata[16:0];
            end
            mgpu_pkg::REG_ATTRACTION_SCALE: begin
               attraction_scale_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   mgpu_pkg::cfg_type      cfg;
   mgpu_pkg::lane_in_type  lane_in_x;
   mgpu_pkg::lane_in_type  lane_in_y;
   mgpu_pkg::lane_out_type lane_out_x;
   mgpu_pkg::lane_out_type lane_out_y;
   logic                   accept;

   // fully pipelined: never stall the request side
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cfg                     = '0;
      cfg.learning_rate       = learning_rate_ff;
      cfg.force_normalization = force_normalization_ff;
      cfg.momentum_factor     = momentum_factor_ff;
      cfg.attraction_scale    = attraction_scale_ff;

      lane_in_x         = '0;
      lane_in_x.valid   = accept;
      lane_in_x.tag     = req_data.last_point_in;
      lane_in_x.point   = req_data.point_x;
      lane_in_x.attract = req_data.attract_x;
      lane_in_x.repel   = req_data.repel_x;
      lane_in_x.prev    = req_data.prev_step_x;
      lane_in_x.gain    = req_data.gain_in_x;

      lane_in_y         = '0;
      lane_in_y.valid   = accept;
      lane_in_y.tag     = req_data.last_point_in;
      lane_in_y.point   = req_data.point_y;
      lane_in_y.attract = req_data.attract_y;
      lane_in_y.repel   = req_data.repel_y;
      lane_in_y.prev    = req_data.prev_step_y;
      lane_in_y.gain    = req_data.gain_in_y;
   end

   mgpu_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .lane_in  (lane_in_x),
      .lane_out (lane_out_x)
   );

   mgpu_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .lane_in  (lane_in_y),
      .lane_out (lane_out_y)
   );

   mgpu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_x    (lane_out_x),
      .lane_y    (lane_out_y),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/mgpu_lane.sv
// One axis lane: gradient with pipelined divider, gain update, momentum step, point move.
module mgpu_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  mgpu_pkg::cfg_type      cfg,
   input  mgpu_pkg::lane_in_type  lane_in,
   output mgpu_pkg::lane_out_type lane_out
);

   localparam int DB = mgpu_pkg::DIV_BITS;

   logic [30:0]        norm_eff;
   logic [31:0]        rep_mag;
   logic signed [63:0] a_prod;
   mgpu_pkg::div_type  dv_in;
   mgpu_pkg::div_type  dv_ff [0:DB];
   logic [DB:0]        vld_ff;

   assign norm_eff = (cfg.force_normalization == 31'd0) ? 31'd1 : cfg.force_normalization;

   // magnitude of the most negative value still fits unsigned 32 bits
   assign rep_mag = lane_in.repel[31] ? 32'(-lane_in.repel) : 32'(lane_in.repel);
   assign a_prod  = $signed({1'b0, cfg.attraction_scale}) * lane_in.attract;

   always_comb begin
      dv_in       = '0;
      dv_in.qd    = {rep_mag, 16'h0000};
      dv_in.rem   = '0;
      dv_in.neg   = lane_in.repel[31];
      dv_in.attr  = a_prod[62:16];
      dv_in.point = lane_in.point;
      dv_in.prev  = lane_in.prev;
      dv_in.gain  = lane_in.gain;
      dv_in.tag   = lane_in.tag;
   end

   always_ff @(posedge clock) begin
      dv_ff[0] <= dv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DB-1:0], lane_in.valid};
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DB; k++) begin : g_div
      logic [31:0]       shifted;
      logic              ge;
      mgpu_pkg::div_type nxt;

      assign shifted = {dv_ff[k].rem, dv_ff[k].qd[DB-1]};
      assign ge      = shifted >= {1'b0, norm_eff};

      always_comb begin
         nxt     = dv_ff[k];
         nxt.qd  = {dv_ff[k].qd[DB-2:0], ge};
         nxt.rem = ge ? 31'(shifted - {1'b0, norm_eff}) : shifted[30:0];
      end

      always_ff @(posedge clock) begin
         dv_ff[k+1] <= nxt;
      end
   end

   // gradient and both gain candidates
   logic [49:0]        r_val;
   logic signed [49:0] d_val;
   logic [31:0]        gadd;
   logic [46:0]        gmul_prod;

   logic               p1_vld_ff;
   logic signed [31:0] p1_g_ff;
   logic [30:0]        p1_gadd_ff;
   logic [30:0]        p1_gmul_ff;
   logic signed [31:0] p1_point_ff;
   logic signed [31:0] p1_prev_ff;
   logic               p1_tag_ff;

   assign r_val = dv_ff[DB].neg ? 50'(-{2'b00, dv_ff[DB].qd}) : {2'b00, dv_ff[DB].qd};
   assign d_val = $signed({{3{dv_ff[DB].attr[46]}}, dv_ff[DB].attr}) - $signed(r_val);
   assign gadd  = {1'b0, dv_ff[DB].gain} + 32'(mgpu_pkg::GAIN_ADD);
   assign gmul_prod = 47'(dv_ff[DB].gain) * 47'(mgpu_pkg::GAIN_MUL);

   always_ff @(posedge clock) begin
      p1_g_ff     <= mgpu_pkg::sat32(d_val);
      p1_gadd_ff  <= gadd[31] ? mgpu_pkg::MAX31 : gadd[30:0];
      p1_gmul_ff  <= gmul_prod[46:16];
      p1_point_ff <= dv_ff[DB].point;
      p1_prev_ff  <= dv_ff[DB].prev;
      p1_tag_ff   <= dv_ff[DB].tag;
   end

   // pick gain: grow when gradient and previous step disagree in sign
   logic               grow;
   logic [30:0]        gsel;
   logic               p2_vld_ff;
   logic [30:0]        p2_gn_ff;
   logic signed [31:0] p2_g_ff;
   logic signed [31:0] p2_point_ff;
   logic signed [31:0] p2_prev_ff;
   logic               p2_tag_ff;

   assign grow = p1_g_ff[31] != p1_prev_ff[31];
   assign gsel = grow ? p1_gadd_ff : p1_gmul_ff;

   always_ff @(posedge clock) begin
      p2_gn_ff    <= (gsel < mgpu_pkg::GAIN_FLOOR) ? mgpu_pkg::GAIN_FLOOR : gsel;
      p2_g_ff     <= p1_g_ff;
      p2_point_ff <= p1_point_ff;
      p2_prev_ff  <= p1_prev_ff;
      p2_tag_ff   <= p1_tag_ff;
   end

   // eta times gain, and momentum term
   logic [61:0]        e_prod;
   logic signed [49:0] m_prod;
   logic               p3_vld_ff;
   logic [30:0]        p3_e_ff;
   logic signed [32:0] p3_m_ff;
   logic signed [31:0] p3_g_ff;
   logic [30:0]        p3_gn_ff;
   logic signed [31:0] p3_point_ff;
   logic               p3_tag_ff;

   assign e_prod = 62'(cfg.learning_rate) * 62'(p2_gn_ff);
   assign m_prod = $signed({1'b0, cfg.momentum_factor}) * p2_prev_ff;

   always_ff @(posedge clock) begin
      p3_e_ff     <= (|e_prod[61:47]) ? mgpu_pkg::MAX31 : e_prod[46:16];
      p3_m_ff     <= m_prod[48:16];
      p3_g_ff     <= p2_g_ff;
      p3_gn_ff    <= p2_gn_ff;
      p3_point_ff <= p2_point_ff;
      p3_tag_ff   <= p2_tag_ff;
   end

   // scaled gradient step
   logic signed [63:0] eg_prod;
   logic               p4_vld_ff;
   logic signed [46:0] p4_eg_ff;
   logic signed [32:0] p4_m_ff;
   logic [30:0]        p4_gn_ff;
   logic signed [31:0] p4_point_ff;
   logic               p4_tag_ff;

   assign eg_prod = $signed({1'b0, p3_e_ff}) * p3_g_ff;

   always_ff @(posedge clock) begin
      p4_eg_ff    <= eg_prod[62:16];
      p4_m_ff     <= p3_m_ff;
      p4_gn_ff    <= p3_gn_ff;
      p4_point_ff <= p3_point_ff;
      p4_tag_ff   <= p3_tag_ff;
   end

   // new update
   logic signed [49:0] u_diff;
   logic               p5_vld_ff;
   logic signed [31:0] p5_u_ff;
   logic [30:0]        p5_gn_ff;
   logic signed [31:0] p5_point_ff;
   logic               p5_tag_ff;

   assign u_diff = $signed({{17{p4_m_ff[32]}}, p4_m_ff})
                 - $signed({{3{p4_eg_ff[46]}}, p4_eg_ff});

   always_ff @(posedge clock) begin
      p5_u_ff     <= mgpu_pkg::sat32(u_diff);
      p5_gn_ff    <= p4_gn_ff;
      p5_point_ff <= p4_point_ff;
      p5_tag_ff   <= p4_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= vld_ff[DB];
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
      end
   end

   logic signed [49:0] p_sum;
   assign p_sum = $signed({{18{p5_point_ff[31]}}, p5_point_ff})
                + $signed({{18{p5_u_ff[31]}}, p5_u_ff});

   always_comb begin
      lane_out           = '0;
      lane_out.valid     = p5_vld_ff;
      lane_out.tag       = p5_tag_ff;
      lane_out.new_point = mgpu_pkg::sat32(p_sum);
      lane_out.new_step  = p5_u_ff;
      lane_out.gain_out  = p5_gn_ff;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      lane_in.valid |-> ##(mgpu_pkg::LANE_LAT) lane_out.valid)
      else $error("lane word did not arrive at the fixed latency");

   a_gain_floor: assert property (@(posedge clock) disable iff (reset)
      lane_out.valid |-> (lane_out.gain_out >= mgpu_pkg::GAIN_FLOOR))
      else $error("gain below floor");

   a_move_dir: assert property (@(posedge clock) disable iff (reset)
      (p5_vld_ff && !p5_u_ff[31]) |-> (lane_out.new_point >= p5_point_ff))
      else $error("non-negative update moved point backward");

endmodule

FILE: sv/mgpu_merge.sv
// Output stage: joins the two axis lanes into one registered result word.
module mgpu_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  mgpu_pkg::lane_out_type lane_x,
   input  mgpu_pkg::lane_out_type lane_y,
   output logic                   rsp_valid,
   output mgpu_pkg::rsp_type      rsp_data
);

   logic              rsp_valid_ff;
   mgpu_pkg::rsp_type rsp_data_ff;
   mgpu_pkg::rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.new_point_x    = lane_x.new_point;
      rsp_data_in.new_point_y    = lane_y.new_point;
      rsp_data_in.new_step_x     = lane_x.new_step;
      rsp_data_in.new_step_y     = lane_y.new_step;
      rsp_data_in.gain_out_x     = lane_x.gain_out;
      rsp_data_in.gain_out_y     = lane_y.gain_out;
      rsp_data_in.last_point_out = lane_x.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lane_x.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_x.valid == lane_y.valid)
      else $error("axis lanes out of step");

   a_tags_match: assert property (@(posedge clock) disable iff (reset)
      lane_x.valid |-> (lane_x.tag == lane_y.tag))
      else $error("axis lanes carry different last marks");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(lane_x.valid))
      else $error("result strobe without lane word");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the momentum/adaptive-gain point update block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PIPE_DEPTH  = 55;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 8;
   localparam int          PHASE_WORDS = 244;
   localparam int          PRINT_CAP   = 40;

   localparam longint      Q_HI        = 64'sd2147483647;
   localparam longint      Q_LO        = -64'sd2147483648;
   localparam longint      GAIN_TOP    = 64'sd2147483647;
   localparam longint      GAIN_STEP   = 64'sd13107;
   localparam longint      GAIN_DECAY  = 64'sd52429;
   localparam longint      GAIN_MIN    = 64'sd655;

   localparam logic signed [31:0] QMAX = 32'sh7fffffff;
   localparam logic signed [31:0] QMIN = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sh00010000;
   localparam logic [30:0]        GMAX = 31'h7fffffff;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   mgpu_pkg::req_type req_data = '0;
   logic              rsp_valid;
   mgpu_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [30:0]       csr_wdata = '0;

   mgpu_pkg::cfg_type cfg_now;
   mgpu_pkg::req_type point_queue[$];
   mgpu_pkg::rsp_type expected_moves[$];
   int                mismatch_count = 0;
   int                gap_left = 0;
   logic              burst = 1'b0;
   int unsigned       cycle_count = 0;

   momentum_gain_point_update u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   function automatic longint clip32(input longint v);
      if (v > Q_HI) begin
         return Q_HI;
      end else if (v < Q_LO) begin
         return Q_LO;
      end
      return v;
   endfunction

   // One axis: gradient, adaptive gain, momentum update, moved coordinate.
   function automatic void move_axis(input mgpu_pkg::cfg_type c,
                                     input logic signed [31:0] pt, at, rp, pv,
                                     input logic [30:0] gain,
                                     output logic signed [31:0] np, nu,
                                     output logic [30:0] ng);
      longint norm, a, r, g, gn, e, u, p, prev, scale, lr, mom;
      norm  = (c.force_normalization == '0) ? 64'sd1 : longint'(c.force_normalization);
      scale = longint'(c.attraction_scale);
      lr    = longint'(c.learning_rate);
      mom   = longint'(c.momentum_factor);
      prev  = longint'(pv);
      a = (scale * longint'(at)) >>> 16;
      r = (longint'(rp) * 64'sd65536) / norm;
      g = clip32(a - r);
      // zero gradient counts as non-negative
      if ((g < 0) != (prev < 0)) begin
         gn = longint'(gain) + GAIN_STEP;
         if (gn > GAIN_TOP) gn = GAIN_TOP;
      end else begin
         gn = (longint'(gain) * GAIN_DECAY) >>> 16;
      end
      if (gn < GAIN_MIN) gn = GAIN_MIN;
      e = (lr * gn) >>> 16;
      if (e > GAIN_TOP) e = GAIN_TOP;
      u = clip32(((mom * prev) >>> 16) - ((e * g) >>> 16));
      p = clip32(longint'(pt) + u);
      np = p[31:0];
      nu = u[31:0];
      ng = gn[30:0];
   endfunction

   function automatic mgpu_pkg::rsp_type moved_point(input mgpu_pkg::req_type w,
                                                     input mgpu_pkg::cfg_type c);
      mgpu_pkg::rsp_type m;
      logic signed [31:0] px, py, ux, uy;
      logic [30:0] gx, gy;
      move_axis(c, w.point_x, w.attract_x, w.repel_x, w.prev_step_x, w.gain_in_x, px, ux, gx);
      move_axis(c, w.point_y, w.attract_y, w.repel_y, w.prev_step_y, w.gain_in_y, py, uy, gy);
      m.new_point_x    = px;
      m.new_point_y    = py;
      m.new_step_x     = ux;
      m.new_step_y     = uy;
      m.gain_out_x     = gx;
      m.gain_out_y     = gy;
      m.last_point_out = w.last_point_in;
      return m;
   endfunction

   function automatic logic [31:0] rand_q();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 32'h00000000;
               1: v = 32'h00000001;
               2: v = 32'hffffffff;
               3: v = 32'h7fffffff;
               default: v = 32'h80000000;
            endcase
         end
         1, 2, 3: v = $urandom();
         // plausible forces and coordinates, roughly +-16.0
         default: v = $urandom_range(0, 32'h200000) - 32'h100000;
      endcase
      return v;
   endfunction

   function automatic logic [30:0] rand_gain();
      logic [30:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 31'd0;
               1: v = 31'd654;
               2: v = 31'd655;
               3: v = GMAX;
               default: v = GMAX - 31'd13106 + 31'($urandom_range(0, 3));
            endcase
         end
         1: v = 31'($urandom() >> 1);
         default: v = 31'($urandom_range(0, 655360));
      endcase
      return v;
   endfunction

   function automatic mgpu_pkg::req_type random_point();
      mgpu_pkg::req_type w;
      w.point_x       = rand_q();
      w.point_y       = rand_q();
      w.attract_x     = rand_q();
      w.attract_y     = rand_q();
      w.repel_x       = rand_q();
      w.repel_y       = rand_q();
      w.prev_step_x   = rand_q();
      w.prev_step_y   = rand_q();
      w.gain_in_x     = rand_gain();
      w.gain_in_y     = rand_gain();
      w.last_point_in = ($urandom_range(0, 15) == 0);
      return w;
   endfunction

   function automatic mgpu_pkg::req_type mk_word(
         input logic signed [31:0] px, py, ax, ay, rx, ry, ux, uy,
         input logic [30:0] gx, gy, input logic last);
      mgpu_pkg::req_type w;
      w.point_x       = px;
      w.point_y       = py;
      w.attract_x     = ax;
      w.attract_y     = ay;
      w.repel_x       = rx;
      w.repel_y       = ry;
      w.prev_step_x   = ux;
      w.prev_step_y   = uy;
      w.gain_in_x     = gx;
      w.gain_in_y     = gy;
      w.last_point_in = last;
      return w;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $time);
      end
      mismatch_count++;
   endtask

   task automatic wait_idle();
      while (point_queue.size() != 0 || start || gap_left != 0 || expected_moves.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic program_regs(input mgpu_pkg::cfg_type c, input logic [30:0] mom_word);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= mgpu_pkg::REG_LEARNING_RATE;
      csr_wdata <= c.learning_rate;
      @(posedge clock);
      csr_index <= mgpu_pkg::REG_FORCE_NORMALIZATION;
      csr_wdata <= c.force_normalization;
      @(posedge clock);
      csr_index <= mgpu_pkg::REG_MOMENTUM_FACTOR;
      csr_wdata <= mom_word;
      @(posedge clock);
      csr_index <= mgpu_pkg::REG_ATTRACTION_SCALE;
      csr_wdata <= c.attraction_scale;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_now = c;
      cfg_now.momentum_factor = mom_word[16:0];
   endtask

   // Driver: present queued point words, with random gaps between them.
   always @(posedge clock) begin
      logic go;
      go = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_moves.push_back(moved_point(req_data, cfg_now));
         end
         // hold the word while the block is busy
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (point_queue.size() > 0) begin
               req_data <= point_queue.pop_front();
               go = 1'b1;
               if ($urandom_range(0, 31) == 0) burst = !burst;
               gap_left = burst ? 0 : $urandom_range(0, 17);
            end
            start <= go;
         end
      end
   end

   // Monitor: every strobed result word is checked against the oldest expectation.
   always @(posedge clock) begin
      mgpu_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_moves.size() == 0) begin
            report_mismatch("unexpected word, new_point_x", rsp_data.new_point_x, '0);
         end else begin
            want = expected_moves.pop_front();
            if (rsp_data.new_point_x !== want.new_point_x)
               report_mismatch("new_point_x", rsp_data.new_point_x, want.new_point_x);
            if (rsp_data.new_point_y !== want.new_point_y)
               report_mismatch("new_point_y", rsp_data.new_point_y, want.new_point_y);
            if (rsp_data.new_step_x !== want.new_step_x)
               report_mismatch("new_step_x", rsp_data.new_step_x, want.new_step_x);
            if (rsp_data.new_step_y !== want.new_step_y)
               report_mismatch("new_step_y", rsp_data.new_step_y, want.new_step_y);
            if (rsp_data.gain_out_x !== want.gain_out_x)
               report_mismatch("gain_out_x", rsp_data.gain_out_x, want.gain_out_x);
            if (rsp_data.gain_out_y !== want.gain_out_y)
               report_mismatch("gain_out_y", rsp_data.gain_out_y, want.gain_out_y);
            if (rsp_data.last_point_out !== want.last_point_out)
               report_mismatch("last_point_out", rsp_data.last_point_out, want.last_point_out);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** momentum_gain_point_update: FAILED **");
         $finish;
      end
   end

   initial begin
      mgpu_pkg::cfg_type c;
      logic [30:0]       mom_word;
      cfg_now.learning_rate       = 31'd13107200;
      cfg_now.force_normalization = 31'd65536;
      cfg_now.momentum_factor     = 17'd32768;
      cfg_now.attraction_scale    = 31'd65536;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset settings
      point_queue.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      point_queue.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      // gradient sign opposite to the previous step: gain grows
      point_queue.push_back(mk_word(ONE, -ONE, ONE, -ONE, 0, 0, -ONE, ONE,
                                    31'h10000, 31'h10000, 1'b0));
      // zero gradient against a negative previous step
      point_queue.push_back(mk_word(ONE, ONE, 0, 0, 0, 0, -ONE, -ONE, 31'h10000, 0, 1'b0));
      // gain at the top grows and saturates, then decays; eta times gain saturates
      point_queue.push_back(mk_word(0, 0, ONE, -ONE, 0, 0, -ONE, ONE, GMAX, GMAX, 1'b0));
      point_queue.push_back(mk_word(0, 0, ONE, -ONE, 0, 0, ONE, -ONE, GMAX, GMAX, 1'b1));
      // shrunken gain clamps at the floor
      point_queue.push_back(mk_word(0, 0, -ONE, ONE, 0, 0, -ONE, ONE, 0, 31'd654, 1'b0));
      point_queue.push_back(mk_word(QMAX, QMIN, QMIN, QMAX, 0, 0, QMAX, QMIN, GMAX, GMAX, 1'b0));
      point_queue.push_back(mk_word(QMIN, QMAX, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX,
                                    31'd655, 31'd655, 1'b0));
      point_queue.push_back(mk_word(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
                                    GMAX, GMAX, 1'b1));
      point_queue.push_back(mk_word(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
                                    0, 0, 1'b0));
      point_queue.push_back(mk_word(-1, -1, -1, -1, -1, -1, -1, -1, 1, 1, 1'b1));
      point_queue.push_back(mk_word(1, -1, 1, -1, -1, 1, 1, -1, 31'd13107, 31'd52429, 1'b0));
      point_queue.push_back(mk_word(3 * ONE, -5 * ONE, 32'sh8000, -32'sh8000, 7 * ONE, -2 * ONE,
                                    32'sh4000, -32'sh2000, 31'h10000, 31'h20000, 1'b0));

      for (int k = 0; k < PHASES; k++) begin
         if (k > 0) begin
            wait_idle();
            case (k)
               1: begin
                  // all at the top; momentum word with high bits set
                  c.learning_rate       = GMAX;
                  c.force_normalization = GMAX;
                  c.attraction_scale    = GMAX;
                  mom_word              = GMAX;
               end
               2: begin
                  // zero normalization acts as one
                  c.learning_rate       = '0;
                  c.force_normalization = '0;
                  c.attraction_scale    = '0;
                  mom_word              = '0;
               end
               3: begin
                  c.learning_rate       = 31'($urandom_range(0, 1 << 24));
                  c.force_normalization = 31'd1;
                  c.attraction_scale    = 31'($urandom_range(65536, 12 * 65536));
                  mom_word              = 31'd65536;
               end
               default: begin
                  c.learning_rate = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                         : 31'($urandom_range(0, 400 * 65536));
                  c.force_normalization = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                 : 31'($urandom_range(1, 64 * 65536));
                  c.attraction_scale = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                 : 31'($urandom_range(0, 12 * 65536));
                  mom_word = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                  : 31'($urandom_range(0, 65536));
               end
            endcase
            program_regs(c, mom_word);
         end
         repeat (PHASE_WORDS) point_queue.push_back(random_point());
      end

      wait_idle();
      // let any stray word drain out of the pipeline
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** momentum_gain_point_update: PASSED **");
      end else begin
         $display("** momentum_gain_point_update: FAILED **");
      end
      $finish;
   end

endmodule
